### sv/btpc_pkg.sv
// Shared widths, register indexes and stage bundle types for the compensation core.
`default_nettype none

package btpc_pkg;

    localparam int UP_W     = 24;
    localparam int DT_W     = 25;
    localparam int PROD_W   = 42;
    localparam int DSQ_W    = 2 * DT_W;
    localparam int TEMP_W   = 19;
    localparam int T2_W     = 17;
    localparam int SQ_W     = 36;
    localparam int WIDE_W   = 42;
    localparam int P_W      = 32;
    localparam int CAL_W    = 16;
    localparam int CFG_A_W  = 3;

    localparam int TEMP_SHIFT = 23;
    localparam int T2_SHIFT   = 31;

    localparam logic signed [TEMP_W-1:0] TEMP_REF      = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] LOW_BIAS      = TEMP_W'(3500);
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_D   = -TEMP_W'(3500);

    localparam logic [CFG_A_W-1:0] REG_CAL_C1  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_CAL_C2  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_CAL_C3  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_CAL_C4  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_CAL_C5  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_CAL_C6  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_VARIANT = 3'd6;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
        logic             variant;
    } cal_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_ld_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic        [T2_W-1:0]   t2;
        logic signed [TEMP_W-1:0] d;
        logic signed [TEMP_W-1:0] e;
        logic                     below_ref;
        logic                     below_low;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic        [UP_W-1:0]   up;
    } first_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic        [UP_W-1:0]   up;
    } comp_t;

endpackage

`default_nettype wire

### sv/btpc_front.sv
// First-order stages: dT, calibration products, temperature, offset and sensitivity.
`default_nettype none

module btpc_front (
    input  wire                        clk,
    input  wire btpc_pkg::stage_ld_t   ld,
    input  wire btpc_pkg::cal_t        cal,
    input  wire [btpc_pkg::UP_W-1:0]   raw_temperature,
    input  wire [btpc_pkg::UP_W-1:0]   raw_pressure,
    output btpc_pkg::first_t           res
);
    import btpc_pkg::*;

    logic signed [DT_W-1:0]   dt_reg;
    logic        [UP_W-1:0]   up1_reg;
    logic signed [PROD_W-1:0] p6_reg;
    logic signed [PROD_W-1:0] p4_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic signed [DSQ_W-1:0]  dsq_reg;
    logic        [UP_W-1:0]   up2_reg;
    first_t                   res_reg;

    logic signed [DT_W-1:0]   dt_next;
    logic signed [PROD_W-1:0] p6_next;
    logic signed [PROD_W-1:0] p4_next;
    logic signed [PROD_W-1:0] p3_next;
    logic signed [DSQ_W-1:0]  dsq_next;
    logic signed [TEMP_W-1:0] d;
    logic signed [WIDE_W-1:0] off_base;
    logic signed [WIDE_W-1:0] sens_base;
    logic signed [WIDE_W-1:0] off_lin;
    logic signed [WIDE_W-1:0] sens_lin;
    first_t                   res_next;

    always_comb
    begin
        dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});
    end

    always_comb
    begin
        p6_next  = dt_reg * $signed({1'b0, cal.c6});
        p4_next  = dt_reg * $signed({1'b0, cal.c4});
        p3_next  = dt_reg * $signed({1'b0, cal.c3});
        dsq_next = dt_reg * dt_reg;
    end

    always_comb
    begin
        d = p6_reg[PROD_W-1:TEMP_SHIFT];
        if (cal.variant)
        begin
            off_base  = $signed(WIDE_W'({cal.c2, 17'd0}));
            off_lin   = p4_reg >>> 6;
            sens_base = $signed(WIDE_W'({cal.c1, 16'd0}));
            sens_lin  = p3_reg >>> 7;
        end
        else
        begin
            off_base  = $signed(WIDE_W'({cal.c2, 16'd0}));
            off_lin   = p4_reg >>> 7;
            sens_base = $signed(WIDE_W'({cal.c1, 15'd0}));
            sens_lin  = p3_reg >>> 8;
        end
        res_next.temp      = d + TEMP_REF;
        res_next.t2        = dsq_reg[T2_SHIFT+T2_W-1:T2_SHIFT];
        res_next.d         = d;
        res_next.e         = d + LOW_BIAS;
        res_next.below_ref = d[TEMP_W-1];
        res_next.below_low = (d < LOW_LIMIT_D);
        res_next.off       = off_base + off_lin;
        res_next.sens      = sens_base + sens_lin;
        res_next.up        = up2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            dt_reg  <= dt_next;
            up1_reg <= raw_pressure;
        end
        if (ld.s2)
        begin
            p6_reg  <= p6_next;
            p4_reg  <= p4_next;
            p3_reg  <= p3_next;
            dsq_reg <= dsq_next;
            up2_reg <= up1_reg;
        end
        if (ld.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### sv/btpc_corr.sv
// Second-order correction stages for offset, sensitivity and temperature.
`default_nettype none

module btpc_corr (
    input  wire                       clk,
    input  wire btpc_pkg::stage_ld_t  ld,
    input  wire                       variant,
    input  wire btpc_pkg::first_t     first,
    output btpc_pkg::comp_t           res
);
    import btpc_pkg::*;

    logic [SQ_W-1:0]          t_reg;
    logic [SQ_W-1:0]          u_reg;
    first_t                   f1_reg;
    logic [WIDE_W-1:0]        off2_reg;
    logic [WIDE_W-1:0]        sens2_reg;
    logic signed [TEMP_W-1:0] temp2_reg;
    logic signed [WIDE_W-1:0] off1_reg;
    logic signed [WIDE_W-1:0] sens1_reg;
    logic [UP_W-1:0]          up2_reg;
    comp_t                    res_reg;

    logic signed [2*TEMP_W-1:0] dd;
    logic signed [2*TEMP_W-1:0] ee;
    logic [WIDE_W-1:0]          tw;
    logic [WIDE_W-1:0]          uw;
    logic [WIDE_W-1:0]          off_a;
    logic [WIDE_W-1:0]          off_b;
    logic [WIDE_W-1:0]          sens_a;
    logic [WIDE_W-1:0]          sens_b;
    logic [WIDE_W-1:0]          off2_next;
    logic [WIDE_W-1:0]          sens2_next;
    logic signed [TEMP_W-1:0]   temp2_next;
    comp_t                      res_next;

    always_comb
    begin
        dd = first.d * first.d;
        ee = first.e * first.e;
    end

    always_comb
    begin
        tw = WIDE_W'(t_reg);
        uw = f1_reg.below_low ? WIDE_W'(u_reg) : '0;
        if (variant)
        begin
            off_a  = (tw * WIDE_W'(61)) >> 4;
            off_b  = uw * WIDE_W'(15);
            sens_a = tw << 1;
            sens_b = uw << 3;
        end
        else
        begin
            off_a  = (tw * WIDE_W'(5)) >> 1;
            off_b  = uw * WIDE_W'(7);
            sens_a = (tw * WIDE_W'(5)) >> 2;
            sens_b = (uw * WIDE_W'(11)) >> 1;
        end
        if (f1_reg.below_ref)
        begin
            off2_next  = off_a + off_b;
            sens2_next = sens_a + sens_b;
            temp2_next = f1_reg.temp - $signed(TEMP_W'(f1_reg.t2));
        end
        else
        begin
            off2_next  = '0;
            sens2_next = '0;
            temp2_next = f1_reg.temp;
        end
    end

    always_comb
    begin
        res_next.temp = temp2_reg;
        res_next.off  = off1_reg - $signed(off2_reg);
        res_next.sens = sens1_reg - $signed(sens2_reg);
        res_next.up   = up2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            t_reg  <= dd[SQ_W-1:0];
            u_reg  <= ee[SQ_W-1:0];
            f1_reg <= first;
        end
        if (ld.s2)
        begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            temp2_reg <= temp2_next;
            off1_reg  <= f1_reg.off;
            sens1_reg <= f1_reg.sens;
            up2_reg   <= f1_reg.up;
        end
        if (ld.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### sv/btpc_press.sv
// Pressure stages: split product, scaling, offset removal and saturation.
`default_nettype none

module btpc_press (
    input  wire                                  clk,
    input  wire btpc_pkg::stage_ld_t             ld,
    input  wire btpc_pkg::comp_t                 comp,
    output logic signed [btpc_pkg::TEMP_W-1:0]   temperature_centi,
    output logic signed [btpc_pkg::P_W-1:0]      pressure_q4
);
    import btpc_pkg::*;

    localparam int LO_W  = 20;
    localparam int HI_W  = WIDE_W - LO_W;
    localparam int PL_W  = UP_W + LO_W;
    localparam int PH_W  = UP_W + 1 + HI_W;
    localparam int PRD_W = PH_W + LO_W;
    localparam int Q_W   = PRD_W - 21;
    localparam int R_W   = Q_W + 1;
    localparam int PS_W  = R_W - 11;

    logic        [PL_W-1:0]   pl_reg;
    logic signed [PH_W-1:0]   ph_reg;
    logic signed [WIDE_W-1:0] off_g_reg;
    logic signed [TEMP_W-1:0] temp_g_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [WIDE_W-1:0] off_h_reg;
    logic signed [TEMP_W-1:0] temp_h_reg;
    logic signed [P_W-1:0]    press_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic        [PL_W-1:0]   pl_next;
    logic signed [PH_W-1:0]   ph_next;
    logic        [PRD_W-1:0]  prod;
    logic signed [R_W-1:0]    r;
    logic signed [PS_W-1:0]   ps;
    logic signed [P_W-1:0]    press_next;

    always_comb
    begin
        pl_next = comp.up * comp.sens[LO_W-1:0];
        ph_next = $signed({1'b0, comp.up}) * $signed(comp.sens[WIDE_W-1:LO_W]);
    end

    always_comb
    begin
        prod = {ph_reg, {LO_W{1'b0}}} + PRD_W'(pl_reg);
    end

    always_comb
    begin
        r  = q_reg - off_h_reg;
        ps = r[R_W-1:11];
        if (ps[PS_W-1:P_W-1] == '0 || ps[PS_W-1:P_W-1] == '1)
        begin
            press_next = ps[P_W-1:0];
        end
        else if (ps[PS_W-1])
        begin
            press_next = {1'b1, {(P_W-1){1'b0}}};
        end
        else
        begin
            press_next = {1'b0, {(P_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            off_g_reg  <= comp.off;
            temp_g_reg <= comp.temp;
        end
        if (ld.s2)
        begin
            q_reg      <= $signed(prod[PRD_W-1:21]);
            off_h_reg  <= off_g_reg;
            temp_h_reg <= temp_g_reg;
        end
        if (ld.s3)
        begin
            press_reg <= press_next;
            temp_reg  <= temp_h_reg;
        end
    end

    assign temperature_centi = temp_reg;
    assign pressure_q4       = press_reg;

endmodule

`default_nettype wire

### sv/baro_temp_pressure_compensation_core.sv
// Top level: calibration registers, pipeline flow control and the three stage groups.
//
//  Channel  Direction  Signals                         Payload
//  s_axis   in         tvalid tready tdata[47:0]       raw_temperature, raw_pressure
//  m_axis   out        tvalid tready tdata[55:0]       temperature_centi, pressure_q4
//  cfg      in         valid ready addr[2:0] data[15:0] calibration word or variant
//
// One transaction can enter every cycle unless all stages are full and the output stalls.
// The core is a nine-stage pipeline, with the split 24x42 pressure product taking
// two of those stages.
// Each stage holds its item while the stage after it is full and stalled, and bubbles
// are squeezed out, so input is taken while a finished result still waits at the output.
// Reset clears the stage valid bits and sets every calibration register to zero.
`default_nettype none

module baro_temp_pressure_compensation_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [18:0] temperature_centi, [50:19] pressure_q4
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_addr,
    input  wire  [15:0] cfg_data
);
    import btpc_pkg::*;

    localparam int NS = 9;

    cal_t                     cal_reg;
    logic [NS-1:0]            v_reg;
    logic [NS-1:0]            v_next;
    logic [NS-1:0]            vin;
    logic [NS-1:0]            adv;
    logic [NS-1:0]            load;
    stage_ld_t                ld_front;
    stage_ld_t                ld_corr;
    stage_ld_t                ld_press;
    first_t                   first;
    comp_t                    comp;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [P_W-1:0]    pressure_q4;
    logic                     in_fire;
    logic                     out_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_CAL_C1:  cal_reg.c1      <= cfg_data;
                REG_CAL_C2:  cal_reg.c2      <= cfg_data;
                REG_CAL_C3:  cal_reg.c3      <= cfg_data;
                REG_CAL_C4:  cal_reg.c4      <= cfg_data;
                REG_CAL_C5:  cal_reg.c5      <= cfg_data;
                REG_CAL_C6:  cal_reg.c6      <= cfg_data;
                REG_VARIANT: cal_reg.variant <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        vin = {v_reg[NS-2:0], s_axis_tvalid};
        adv[NS-1] = !v_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        load   = adv & vin;
        v_next = (adv & vin) | (~adv & v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign ld_front = '{s1: load[0], s2: load[1], s3: load[2]};
    assign ld_corr  = '{s1: load[3], s2: load[4], s3: load[5]};
    assign ld_press = '{s1: load[6], s2: load[7], s3: load[8]};

    btpc_front u_front (
        .clk             (clk),
        .ld              (ld_front),
        .cal             (cal_reg),
        .raw_temperature (s_axis_tdata[23:0]),
        .raw_pressure    (s_axis_tdata[47:24]),
        .res             (first)
    );

    btpc_corr u_corr (
        .clk     (clk),
        .ld      (ld_corr),
        .variant (cal_reg.variant),
        .first   (first),
        .res     (comp)
    );

    btpc_press u_press (
        .clk               (clk),
        .ld                (ld_press),
        .comp              (comp),
        .temperature_centi (temperature_centi),
        .pressure_q4       (pressure_q4)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[NS-1];
    assign m_axis_tdata  = {5'd0, pressure_q4, temperature_centi};
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) ==
            $countones($past(v_reg)) + $past(in_fire) - $past(out_fire)))
        else $error("Pipeline item count does not match accepted and delivered transactions.");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input was offered ready while every stage was full and stalled.");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg == '0) |-> s_axis_tready)
        else $error("Input was not ready while the pipeline was empty.");

    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !adv[0]) |=> v_reg[0])
        else $error("A stalled item was dropped from the first stage.");

endmodule

`default_nettype wire
